// ===== sv/pbl_pkg.sv =====
`timescale 1ns / 1ps
// shared types, register codes and state encoding for the bond length range block
package pbl_pkg;

	// default store depth and fixed field widths
	localparam int ATOM_DEPTH_DEF = 4096;
	localparam int IDX_W          = 12;
	localparam int COORD_W        = 32;
	localparam int BOX_W          = 31;
	localparam int SUM_W          = 64;
	localparam int LEN_W          = 32;
	localparam int CFG_IDX_W      = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BOX_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z = 2'd2;

	// item codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_BOND = 1'b1;

	// one position: index 0 is x, 1 is y, 2 is z
	typedef logic [2:0][COORD_W-1:0] pos_t;
	typedef logic [2:0][BOX_W-1:0]   box_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ_B,
		ST_FETCH,
		ST_DIST,
		ST_ROOT,
		ST_HOLD
	} state_t;

endpackage

// ===== sv/pbl_store.sv =====
`timescale 1ns / 1ps
// atom position memory, one write port and one registered read port
module pbl_store #(
	parameter int DEPTH = pbl_pkg::ATOM_DEPTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  pbl_pkg::pos_t  wr_data,
	input  logic           rd_en,
	input  logic [AW-1:0]  rd_addr,
	input  logic           rd_ok,
	output pbl_pkg::pos_t  rd_data
);

	pbl_pkg::pos_t mem [DEPTH];
	pbl_pkg::pos_t rd_q;
	logic          ok_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
			ok_q <= rd_ok;
		end
	end

	// a slot beyond the store reads as the origin
	assign rd_data = ok_q ? rd_q : '0;

endmodule

// ===== sv/pbl_dist.sv =====
`timescale 1ns / 1ps
// minimum-image squared distance, one shared wrap unit and multiplier over three axes
module pbl_dist (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  pbl_pkg::pos_t                 pos_a,
	input  pbl_pkg::pos_t                 pos_b,
	input  pbl_pkg::box_t                 box,
	output logic                          done,
	output logic [pbl_pkg::SUM_W-1:0]     sum
);

	localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
	localparam logic signed [33:0] SAT_LO = -34'sd2147483648;
	localparam logic [2:0] STEP_LAST = 3'd4;

	pbl_pkg::pos_t                a_q;
	pbl_pkg::pos_t                b_q;
	logic                         busy_q;
	logic                         done_q;
	logic [2:0]                   step_q;
	logic [1:0]                   axis;
	logic signed [31:0]           d_s1;
	logic [62:0]                  sq_s2;
	logic [pbl_pkg::SUM_W-1:0]    acc_q;

	logic [31:0]                  a_w;
	logic [31:0]                  b_w;
	logic [pbl_pkg::BOX_W-1:0]    box_w;
	logic signed [33:0]           diff_w;
	logic signed [33:0]           dbl_w;
	logic signed [33:0]           boxs_w;
	logic signed [33:0]           wrap_w;
	logic signed [31:0]           sat_w;
	logic signed [63:0]           prod_w;

	// steps 0..2 wrap an axis into d_s1; its square is registered in sq_s2 and then added to acc_q
	assign axis = (step_q < 3'd3) ? step_q[1:0] : 2'd0;

	always_comb begin
		a_w    = a_q[axis];
		b_w    = b_q[axis];
		box_w  = box[axis];
		diff_w = $signed({{2{b_w[31]}}, b_w}) - $signed({{2{a_w[31]}}, a_w});
		dbl_w  = diff_w <<< 1;
		boxs_w = $signed({3'b000, box_w});
		if (dbl_w < -boxs_w) begin
			wrap_w = diff_w + boxs_w;
		end else if (dbl_w > boxs_w) begin
			wrap_w = diff_w - boxs_w;
		end else begin
			wrap_w = diff_w;
		end
		if (wrap_w > SAT_HI) begin
			sat_w = SAT_HI[31:0];
		end else if (wrap_w < SAT_LO) begin
			sat_w = SAT_LO[31:0];
		end else begin
			sat_w = wrap_w[31:0];
		end
	end

	assign prod_w = d_s1 * d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= pos_a;
			b_q   <= pos_b;
			acc_q <= '0;
		end else if (busy_q) begin
			d_s1  <= sat_w;
			sq_s2 <= prod_w[62:0];
			if (step_q >= 3'd2) begin
				acc_q <= acc_q + pbl_pkg::SUM_W'(sq_s2);
			end
		end
	end

	assign done = done_q;
	assign sum  = acc_q;

endmodule

// ===== sv/pbl_sqrt.sv =====
`timescale 1ns / 1ps
// floor square root of a 64-bit value, two bits of radicand per cycle
module pbl_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pbl_pkg::SUM_W-1:0]     value,
	output logic                          done,
	output logic [pbl_pkg::LEN_W-1:0]     root
);

	localparam logic [pbl_pkg::SUM_W-1:0] BIT_TOP = pbl_pkg::SUM_W'(1) << (pbl_pkg::SUM_W - 2);

	logic                          busy_q;
	logic                          done_q;
	logic [pbl_pkg::SUM_W-1:0]     rem_q;
	logic [pbl_pkg::SUM_W-1:0]     root_q;
	logic [pbl_pkg::SUM_W-1:0]     bit_q;
	logic [pbl_pkg::SUM_W-1:0]     trial_w;

	assign trial_w = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= value;
			root_q <= '0;
			bit_q  <= BIT_TOP;
		end else if (busy_q) begin
			if (rem_q >= trial_w) begin
				rem_q  <= rem_q - trial_w;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[pbl_pkg::LEN_W-1:0];

endmodule

// ===== sv/periodic_bond_length_range_core.sv =====
`timescale 1ns / 1ps
// top level: periodic minimum-image bond length with running minimum and maximum
//
// input channel (in_valid / in_stall): a transaction carries one item. action
// load writes one atom position into the store and does not stall the input; the
// block is ready again in the next cycle. action bond reads both atoms, forms
// the wrapped squared distance, takes its floor root and folds it into the
// running minimum and maximum. in_stall stays high while a bond is in work.
// output channel (out_valid / out_stall): one transaction per bond, none per
// load. a bond's result is registered from the hold state once the output
// register is free; the next item is taken the cycle after. the work of a bond
// is mostly the 32 iterations of the shared root unit, plus two store reads,
// five steps of the shared wrap/multiply unit and the handoff states.
// while the receiver stalls, a finished result waits in the output register;
// loads keep being accepted and a following bond runs up to its result, then
// waits until the register is taken. the user writes box lengths on the cfg
// port only while the block is idle; the block itself does not enforce this.
// reset clears the box lengths, the running minimum to all ones and the
// running maximum to zero; atom slots hold nothing useful until loaded.
module periodic_bond_length_range_core #(
	parameter int ATOM_DEPTH = pbl_pkg::ATOM_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_wr_en,
	input  logic [pbl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pbl_pkg::BOX_W-1:0]         cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [pbl_pkg::IDX_W-1:0]         load_index,
	input  logic signed [pbl_pkg::COORD_W-1:0] pos_x,
	input  logic signed [pbl_pkg::COORD_W-1:0] pos_y,
	input  logic signed [pbl_pkg::COORD_W-1:0] pos_z,
	input  logic [pbl_pkg::IDX_W-1:0]         end_a,
	input  logic [pbl_pkg::IDX_W-1:0]         end_b,
	input  logic                              first_bond,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pbl_pkg::LEN_W-1:0]         bond_len,
	output logic [pbl_pkg::LEN_W-1:0]         min_len,
	output logic [pbl_pkg::LEN_W-1:0]         max_len
);

	localparam int AW    = $clog2(ATOM_DEPTH);
	localparam int CMP_W = ((AW > pbl_pkg::IDX_W) ? AW : pbl_pkg::IDX_W) + 1;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(ATOM_DEPTH);

	pbl_pkg::state_t                state_q, state_d;
	pbl_pkg::box_t                  box_q;
	pbl_pkg::pos_t                  pos_a_q;
	logic [pbl_pkg::IDX_W-1:0]      end_b_q;
	logic                           first_q;
	logic [pbl_pkg::LEN_W-1:0]      run_min_q;
	logic [pbl_pkg::LEN_W-1:0]      run_max_q;
	logic                           out_valid_q;
	logic [pbl_pkg::LEN_W-1:0]      bond_len_q;

	// store control
	logic                           in_accept;
	logic                           wr_en;
	logic                           rd_en;
	logic [pbl_pkg::IDX_W-1:0]      rd_index;
	logic                           rd_ok;
	pbl_pkg::pos_t                  wr_data;
	pbl_pkg::pos_t                  rd_data;

	// shared units
	logic                           dist_start;
	logic                           dist_done;
	logic [pbl_pkg::SUM_W-1:0]      dist_sum;
	logic                           sqrt_start;
	logic                           sqrt_done;
	logic [pbl_pkg::LEN_W-1:0]      sqrt_root;

	// result register
	logic                           out_free;
	logic                           res_load;
	logic [pbl_pkg::LEN_W-1:0]      min_base;
	logic [pbl_pkg::LEN_W-1:0]      max_base;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// loads beyond the store are dropped
	assign wr_en   = in_accept && (action == pbl_pkg::ACT_LOAD)
		&& (CMP_W'(load_index) < DEPTH_C);
	assign wr_data = {pos_z, pos_y, pos_x};
	// a bond end beyond the store reads as the origin
	assign rd_ok   = CMP_W'(rd_index) < DEPTH_C;

	pbl_store #(
		.DEPTH(ATOM_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(load_index)),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (AW'(rd_index)),
		.rd_ok   (rd_ok),
		.rd_data (rd_data)
	);

	pbl_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.pos_a  (pos_a_q),
		.pos_b  (rd_data),
		.box    (box_q),
		.done   (dist_done),
		.sum    (dist_sum)
	);

	pbl_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (dist_sum),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pbl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		rd_en      = 1'b0;
		rd_index   = end_b_q;
		dist_start = 1'b0;
		sqrt_start = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			pbl_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				rd_index = end_a;
				if (in_valid && (action == pbl_pkg::ACT_BOND)) begin
					rd_en   = 1'b1;
					state_d = pbl_pkg::ST_READ_B;
				end
			end
			pbl_pkg::ST_READ_B: begin
				// first end arrives, second end read goes out
				rd_en   = 1'b1;
				state_d = pbl_pkg::ST_FETCH;
			end
			pbl_pkg::ST_FETCH: begin
				dist_start = 1'b1;
				state_d    = pbl_pkg::ST_DIST;
			end
			pbl_pkg::ST_DIST: begin
				if (dist_done) begin
					sqrt_start = 1'b1;
					state_d    = pbl_pkg::ST_ROOT;
				end
			end
			pbl_pkg::ST_ROOT: begin
				if (sqrt_done) begin
					state_d = pbl_pkg::ST_HOLD;
				end
			end
			pbl_pkg::ST_HOLD: begin
				// root stays put; wait for room in the output register
				if (out_free) begin
					res_load = 1'b1;
					state_d  = pbl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pbl_pkg::ST_IDLE;
			end
		endcase
	end

	// bond context
	always_ff @(posedge clk) begin
		if (in_accept) begin
			end_b_q <= end_b;
			first_q <= first_bond;
		end
		if (state_q == pbl_pkg::ST_READ_B) begin
			pos_a_q <= rd_data;
		end
	end

	// box length registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pbl_pkg::REG_BOX_X: box_q[0] <= cfg_data;
				pbl_pkg::REG_BOX_Y: box_q[1] <= cfg_data;
				pbl_pkg::REG_BOX_Z: box_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// running range, restarted by a first bond before folding in
	assign min_base = first_q ? '1 : run_min_q;
	assign max_base = first_q ? '0 : run_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q   <= '1;
			run_max_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				run_min_q   <= (sqrt_root < min_base) ? sqrt_root : min_base;
				run_max_q   <= (sqrt_root > max_base) ? sqrt_root : max_base;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			bond_len_q <= sqrt_root;
		end
	end

	assign out_valid = out_valid_q;
	assign bond_len  = bond_len_q;
	assign min_len   = run_min_q;
	assign max_len   = run_max_q;

	// checks
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (min_len <= bond_len) && (bond_len <= max_len))
		else $error("bond length outside running range");

	a_bond_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (action == pbl_pkg::ACT_BOND)) |=> in_stall)
		else $error("bond transaction did not stall the input");

	a_dist_seq: assert property (@(posedge clk) disable iff (!arst_n)
		dist_done |-> (state_q == pbl_pkg::ST_DIST))
		else $error("distance finished outside its wait state");

	a_sqrt_seq: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> (state_q == pbl_pkg::ST_ROOT))
		else $error("root finished outside its wait state");

endmodule

// ===== sim/tb_periodic_bond_length_range_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the periodic minimum-image bond length range core
module tb_periodic_bond_length_range_core;

	// store depth, settle time after the last result, random phase count and items per phase
	localparam int ATOM_SLOTS   = pbl_pkg::ATOM_DEPTH_DEF;
	localparam int SETTLE_CYCLES = 60;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 350;

	// coordinate and box extremes and clamp limits: signed q16.16 coordinates, unsigned q15.16 box
	localparam logic signed [pbl_pkg::COORD_W-1:0] C_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [pbl_pkg::COORD_W-1:0] C_MIN   = 32'sh8000_0000;
	localparam logic signed [pbl_pkg::COORD_W-1:0] C_ONE   = 32'sh0001_0000;
	localparam logic [pbl_pkg::BOX_W-1:0]          BOX_MAX = 31'h7FFF_FFFF;
	localparam longint                              SAT_HI  = 64'sd2147483647;
	localparam longint                              SAT_LO  = -64'sd2147483648;

	// one input item, all fields present whatever the action
	typedef struct {
		logic                               act;
		logic [pbl_pkg::IDX_W-1:0]          slot;
		logic signed [pbl_pkg::COORD_W-1:0] px;
		logic signed [pbl_pkg::COORD_W-1:0] py;
		logic signed [pbl_pkg::COORD_W-1:0] pz;
		logic [pbl_pkg::IDX_W-1:0]          ea;
		logic [pbl_pkg::IDX_W-1:0]          eb;
		logic                               fb;
	} bond_item_t;

	// one bond result: length and the running range after it
	typedef struct {
		logic [pbl_pkg::LEN_W-1:0] len;
		logic [pbl_pkg::LEN_W-1:0] low;
		logic [pbl_pkg::LEN_W-1:0] high;
	} len_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// configuration port
	logic                          cfg_wr_en = 1'b0;
	logic [pbl_pkg::CFG_IDX_W-1:0] cfg_index = pbl_pkg::REG_BOX_X;
	logic [pbl_pkg::BOX_W-1:0]     cfg_data  = '0;

	// input channel
	logic                               in_valid   = 1'b0;
	logic                               in_stall;
	logic                               action     = pbl_pkg::ACT_LOAD;
	logic [pbl_pkg::IDX_W-1:0]          load_index = '0;
	logic signed [pbl_pkg::COORD_W-1:0] pos_x      = '0;
	logic signed [pbl_pkg::COORD_W-1:0] pos_y      = '0;
	logic signed [pbl_pkg::COORD_W-1:0] pos_z      = '0;
	logic [pbl_pkg::IDX_W-1:0]          end_a      = '0;
	logic [pbl_pkg::IDX_W-1:0]          end_b      = '0;
	logic                               first_bond = 1'b0;

	// output channel
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [pbl_pkg::LEN_W-1:0] bond_len;
	logic [pbl_pkg::LEN_W-1:0] min_len;
	logic [pbl_pkg::LEN_W-1:0] max_len;

	// predictor state: atom store, box lengths and running range
	pbl_pkg::pos_t             atom_pos[ATOM_SLOTS];
	logic                      atom_loaded[ATOM_SLOTS];
	int                        loaded_slots[$];
	pbl_pkg::box_t             box_len;
	logic [pbl_pkg::LEN_W-1:0] range_min;
	logic [pbl_pkg::LEN_W-1:0] range_max;

	// bond results still owed by the block, oldest first
	len_result_t pending_ranges[$];

	int error_count = 0;

	// idling control shared by sender and receiver; a long receiver hold on request
	bit idle_en = 1'b1;
	int hold_cycles_req = 0;
	int hold_left = 0;
	int stall_left = 0;

	periodic_bond_length_range_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.load_index (load_index),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.end_a      (end_a),
		.end_b      (end_b),
		.first_bond (first_bond),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bond_len   (bond_len),
		.min_len    (min_len),
		.max_len    (max_len)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 94)
			return $urandom_range(1, 4);
		return $urandom_range(15, 80);
	endfunction

	// per-axis minimum-image difference b - a, wrapped once and clamped to 32 bits
	function automatic longint min_image(input longint a, input longint b, input longint n);
		longint d;
		d = b - a;
		if (2 * d < -n)
			d = d + n;
		else if (2 * d > n)
			d = d - n;
		if (d > SAT_HI)
			d = SAT_HI;
		if (d < SAT_LO)
			d = SAT_LO;
		return d;
	endfunction

	// floor square root, one result bit at a time from the top
	function automatic logic [pbl_pkg::LEN_W-1:0] floor_root(
		input logic [pbl_pkg::SUM_W-1:0] v);
		logic [pbl_pkg::LEN_W-1:0] r;
		logic [pbl_pkg::LEN_W-1:0] c;
		logic [pbl_pkg::SUM_W-1:0] sq;
		r = '0;
		for (int i = pbl_pkg::LEN_W - 1; i >= 0; i--) begin
			c  = r | (32'd1 << i);
			sq = {32'b0, c} * {32'b0, c};
			if (sq <= v)
				r = c;
		end
		return r;
	endfunction

	// update the predictor for one accepted item; bonds queue their expected range
	function automatic void predict_bond_range(input bond_item_t it);
		pbl_pkg::pos_t             pa;
		pbl_pkg::pos_t             pb;
		logic [pbl_pkg::SUM_W-1:0] sq_sum;
		longint                    d;
		logic [pbl_pkg::LEN_W-1:0] len;
		if (it.act == pbl_pkg::ACT_LOAD) begin
			atom_pos[it.slot] = {it.pz, it.py, it.px};
			if (!atom_loaded[it.slot]) begin
				atom_loaded[it.slot] = 1'b1;
				loaded_slots.push_back(int'(it.slot));
			end
			return;
		end
		pa = atom_pos[it.ea];
		pb = atom_pos[it.eb];
		sq_sum = '0;
		for (int k = 0; k < 3; k++) begin
			d = min_image(longint'(signed'(pa[k])), longint'(signed'(pb[k])),
				longint'(box_len[k]));
			sq_sum = sq_sum + 64'(d * d);
		end
		len = floor_root(sq_sum);
		// first bond restarts the range before this length is folded in
		if (it.fb) begin
			range_min = '1;
			range_max = '0;
		end
		if (len < range_min)
			range_min = len;
		if (len > range_max)
			range_max = len;
		pending_ranges.push_back('{len, range_min, range_max});
	endfunction

	function automatic bond_item_t make_load(input logic [pbl_pkg::IDX_W-1:0] slot,
		input logic signed [pbl_pkg::COORD_W-1:0] x,
		input logic signed [pbl_pkg::COORD_W-1:0] y,
		input logic signed [pbl_pkg::COORD_W-1:0] z);
		bond_item_t it;
		// bond-only fields carry noise, the block must ignore them
		it = '{pbl_pkg::ACT_LOAD, slot, x, y, z, 12'($urandom), 12'($urandom),
			1'($urandom)};
		return it;
	endfunction

	function automatic bond_item_t make_bond(input logic [pbl_pkg::IDX_W-1:0] a,
		input logic [pbl_pkg::IDX_W-1:0] b, input logic fb);
		bond_item_t it;
		// load-only fields carry noise, the block must ignore them
		it = '{pbl_pkg::ACT_BOND, 12'($urandom), $urandom, $urandom, $urandom, a, b, fb};
		return it;
	endfunction

	// coordinate scaled to the axis box so that wraps happen often
	function automatic logic signed [pbl_pkg::COORD_W-1:0] pick_coord(
		input logic [pbl_pkg::BOX_W-1:0] box);
		int unsigned r;
		int unsigned span;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom;
		if (r == 1) begin
			case ($urandom_range(0, 3))
				0: return C_MIN;
				1: return C_MAX;
				2: return '0;
				default: return -1;
			endcase
		end
		if (box == '0 || r >= 8)
			return $urandom_range(0, 2000000) - 1000000;
		span = {box, 1'b0};
		return 32'($urandom_range(0, span)) - 32'(box);
	endfunction

	function automatic logic [pbl_pkg::BOX_W-1:0] pick_box(input int kind);
		case (kind)
			0: return '0;
			1: return 31'd1;
			2: return BOX_MAX;
			3: return 31'($urandom_range(1, 64)) << 16;
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic bond_item_t random_item();
		logic [pbl_pkg::IDX_W-1:0] a;
		logic [pbl_pkg::IDX_W-1:0] b;
		logic [pbl_pkg::IDX_W-1:0] slot;
		if (loaded_slots.size() == 0 || $urandom_range(0, 99) < 35) begin
			if (loaded_slots.size() != 0 && $urandom_range(0, 1) == 0)
				slot = pbl_pkg::IDX_W'(
					loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
			else
				slot = pbl_pkg::IDX_W'($urandom_range(0, ATOM_SLOTS - 1));
			return make_load(slot, pick_coord(box_len[0]), pick_coord(box_len[1]),
				pick_coord(box_len[2]));
		end
		// bonds only ever name slots that have been loaded
		a = pbl_pkg::IDX_W'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
		if ($urandom_range(0, 9) == 0)
			b = a;
		else
			b = pbl_pkg::IDX_W'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
		return make_bond(a, b, $urandom_range(0, 9) == 0);
	endfunction

	// offer one item, hold it until a transaction takes it, then predict
	task automatic send_item(input bond_item_t it);
		int gap;
		gap = idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action     <= it.act;
		load_index <= it.slot;
		pos_x      <= it.px;
		pos_y      <= it.py;
		pos_z      <= it.pz;
		end_a      <= it.ea;
		end_b      <= it.eb;
		first_bond <= it.fb;
		in_valid   <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		predict_bond_range(it);
	endtask

	// stop offering and let every owed result come back, then settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_ranges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes all three box registers; only called with the block idle
	task automatic set_box(input logic [pbl_pkg::BOX_W-1:0] bx,
		input logic [pbl_pkg::BOX_W-1:0] by, input logic [pbl_pkg::BOX_W-1:0] bz);
		cfg_wr_en <= 1'b1;
		cfg_index <= pbl_pkg::REG_BOX_X;
		cfg_data  <= bx;
		@(posedge clk);
		cfg_index <= pbl_pkg::REG_BOX_Y;
		cfg_data  <= by;
		@(posedge clk);
		cfg_index <= pbl_pkg::REG_BOX_Z;
		cfg_data  <= bz;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		box_len = {bz, by, bx};
	endtask

	task automatic note_error(input string what);
		error_count++;
		if (error_count <= 10)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// no box on any axis: extremes, saturation both ways, same atom, range restart
	task automatic test_zero_box_extremes();
		set_box('0, '0, '0);
		send_item(make_load(12'd0, '0, '0, '0));
		send_item(make_load(12'hFFF, C_MAX, C_MAX, C_MAX));
		send_item(make_load(12'd1, C_MIN, C_MIN, C_MIN));
		send_item(make_load(12'd2, -1, 1, C_ONE));
		send_item(make_load(12'hAAA, 32'sh5555_5555, 32'shAAAA_AAAA, -C_ONE));
		send_item(make_bond(12'd0, 12'd0, 1'b1));
		send_item(make_bond(12'hFFF, 12'd1, 1'b0));
		send_item(make_bond(12'd1, 12'hFFF, 1'b0));
		send_item(make_bond(12'd0, 12'd2, 1'b0));
		send_item(make_bond(12'd2, 12'hAAA, 1'b0));
		send_item(make_bond(12'hFFF, 12'hFFF, 1'b1));
		send_item(make_bond(12'hAAA, 12'd0, 1'b0));
	endtask

	// mixed boxes: wrap both ways, no wrap at exactly half a box, clamp after wrap
	task automatic test_wrap_boundaries();
		drain();
		set_box(31'd10 << 16, BOX_MAX, 31'd1);
		send_item(make_load(12'd3, '0, '0, '0));
		send_item(make_load(12'd4, 32'sd6 <<< 16, 32'sh4000_0000, 32'sd1));
		send_item(make_load(12'd5, 32'sd5 <<< 16, -32'sh4000_0000, -1));
		send_item(make_load(12'd6, -(32'sd6 <<< 16), C_MAX, C_MIN));
		send_item(make_bond(12'd3, 12'd4, 1'b1));
		send_item(make_bond(12'd4, 12'd3, 1'b0));
		send_item(make_bond(12'd3, 12'd5, 1'b0));
		send_item(make_bond(12'd5, 12'd3, 1'b0));
		send_item(make_bond(12'd3, 12'd6, 1'b0));
		send_item(make_bond(12'd1, 12'hFFF, 1'b0));
		send_item(make_bond(12'hFFF, 12'd1, 1'b0));
	endtask

	// random traffic under a sequence of box settings, idling switched in stretches
	task automatic test_random_traffic();
		logic [pbl_pkg::BOX_W-1:0] bx;
		logic [pbl_pkg::BOX_W-1:0] by;
		logic [pbl_pkg::BOX_W-1:0] bz;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			case (ph)
				0: begin bx = pick_box(4); by = pick_box(4); bz = pick_box(4); end
				1: begin bx = pick_box(3); by = pick_box(3); bz = pick_box(3); end
				2: begin bx = pick_box(0); by = pick_box(0); bz = pick_box(0); end
				3: begin bx = pick_box(2); by = pick_box(2); bz = pick_box(2); end
				default: begin
					bx = pick_box($urandom_range(0, 4));
					by = pick_box($urandom_range(0, 4));
					bz = pick_box($urandom_range(0, 4));
				end
			endcase
			set_box(bx, by, bz);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0)
					idle_en = ($urandom_range(0, 3) != 0);
				send_item(random_item());
			end
		end
		idle_en = 1'b1;
	endtask

	// receiver holds off long enough for the block to fill and stall its input
	task automatic test_output_backpressure();
		idle_en = 1'b0;
		hold_cycles_req = 600;
		for (int n = 0; n < 40; n++)
			send_item(random_item());
		idle_en = 1'b1;
	endtask

	// receiver: random stalls, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_cycles_req > 0) begin
			hold_left = hold_cycles_req;
			hold_cycles_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = idle_en ? pick_gap() : 0;
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// result checker: each output transaction against the oldest expectation
	always @(posedge clk) begin
		len_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_ranges.size() == 0) begin
				note_error($sformatf("unexpected result len=%h min=%h max=%h",
					bond_len, min_len, max_len));
			end else begin
				want = pending_ranges.pop_front();
				if (bond_len !== want.len)
					note_error($sformatf("bond_len exp %h got %h", want.len, bond_len));
				if (min_len !== want.low)
					note_error($sformatf("min_len exp %h got %h", want.low, min_len));
				if (max_len !== want.high)
					note_error($sformatf("max_len exp %h got %h", want.high, max_len));
			end
		end
	end

	// predictor reset state mirrors the block's reset
	initial begin
		for (int i = 0; i < ATOM_SLOTS; i++) begin
			atom_pos[i]    = '0;
			atom_loaded[i] = 1'b0;
		end
		box_len   = '0;
		range_min = '1;
		range_max = '0;
	end

	// main sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_box_extremes();
		test_wrap_boundaries();
		test_output_backpressure();
		test_random_traffic();
		drain();
		if (error_count == 0 && pending_ranges.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit, well past the slowest legal run
	initial begin
		#25_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pbl_pkg.sv
sv/pbl_store.sv
sv/pbl_dist.sv
sv/pbl_sqrt.sv
sv/periodic_bond_length_range_core.sv
sim/tb_periodic_bond_length_range_core.sv
